// File: hw/rtl/gpet_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpet_pkg
// Shared types, register codes and a helper function for the gray conversion
// and Prewitt edge threshold block.
// ----------------------------------------------------------------------------
package gpet_pkg;

	localparam int PIX_W    = 8;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;
	localparam int REG_IDX_W = 2;

	// Register indexes (byte address = 4 * index).
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

	localparam logic [10:0] RST_IMAGE_WIDTH    = 11'd640;
	localparam logic [11:0] RST_IMAGE_HEIGHT   = 12'd480;
	localparam logic [10:0] RST_EDGE_THRESHOLD = 11'd150;

	// Smallest usable frame dimension, and the first incoming row or column
	// whose window is processed (the window's anchor is two behind it).
	localparam int MIN_DIM = 3;

	localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
	localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

	// x / 3 for x < 2048 is (x * 683) >> 11.
	localparam int GRAY_RECIP = 683;
	localparam int GRAY_SHIFT = 11;

	typedef struct packed {
		logic [10:0] image_width;
		logic [11:0] image_height;
		logic [10:0] edge_threshold;
	} gpet_cfg_t;

	typedef struct packed {
		logic             frame_last;
		logic             edge_valid;
		logic [PIX_W-1:0] edge_pixel;
		logic [PIX_W-1:0] gray_value;
	} gpet_res_t;

	function automatic logic [PIX_W-1:0] gray_of(
		input logic [PIX_W-1:0] r,
		input logic [PIX_W-1:0] g,
		input logic [PIX_W-1:0] b
	);
		logic [9:0]  sum;
		logic [20:0] prod;
		sum  = 10'(r) + 10'(g) + 10'(b);
		prod = 21'(sum) * 21'(GRAY_RECIP);
		return prod[GRAY_SHIFT+PIX_W-1:GRAY_SHIFT];
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/gpet_pixel_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpet_pixel_if
// Valid/ready channel that carries one RGB pixel per beat.
// ----------------------------------------------------------------------------
interface gpet_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source(output valid, output red, output green, output blue, input ready);
	modport sink(input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/gpet_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpet_result_if
// Valid/ready channel that carries one gray/edge result per beat.
// ----------------------------------------------------------------------------
interface gpet_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] gray_value;
	logic       edge_valid;
	logic [7:0] edge_pixel;
	logic       frame_last;

	modport source(output valid, output gray_value, output edge_valid,
		output edge_pixel, output frame_last, input ready);
	modport sink(input valid, input gray_value, input edge_valid,
		input edge_pixel, input frame_last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/gray_prewitt_edge_threshold.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gray_prewitt_edge_threshold
// RGB to gray conversion with 3x3 Prewitt edge marking on a raster stream.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order, one per beat, and each produces exactly one
// result beat. The result carries the pixel's own gray value (truncated mean
// of red, green and blue) and, for the window whose top-left corner lies two
// rows and two columns behind it, an edge mark: 255 when the signed sum of
// the horizontal and vertical Prewitt responses exceeds edge_threshold, else
// 0. edge_valid flags results whose anchor sits in rows 1..height-3 and
// columns 1..width-3; elsewhere edge_pixel is 0 and the consumer keeps the
// gray value it already has. frame_last marks the final pixel of the frame.
// The block sustains one pixel per clock while results are taken. A pixel
// accepted into the input stage moves on to the output register, from which
// the sink takes it; the rate is set by the line stores, which take one read
// at acceptance and one write as each pixel leaves the input stage. A full
// output register lets the next pixel be accepted while a result still
// waits. Register writes are expected only while the block is idle. Width
// is clamped to 3..MAX_WIDTH and height to at least 3.
// Line store contents are undefined after reset and need no clearing pass:
// a processed window only reads entries written in the current frame
// geometry.
// ----------------------------------------------------------------------------
module gray_prewitt_edge_threshold #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [gpet_pkg::ADDR_W-1:0] paddr,
	input  wire logic [gpet_pkg::DATA_W-1:0] pwdata,
	output logic      [gpet_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	gpet_pixel_if.sink                       pixel,
	gpet_result_if.source                    result
);
	import gpet_pkg::*;

	// Column counter and line store address width; effective width compare
	// needs room for MAX_WIDTH itself and for the 11-bit register.
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = (CW + 1 > 11) ? CW + 1 : 11;

	gpet_cfg_t cfg;

	// Handshake and pipeline control.
	logic accept;
	logic advance;
	logic s1_valid_q;
	logic out_valid_q;

	// Frame position of the next pixel to arrive.
	logic [CW-1:0] col_cnt_q;
	logic [11:0]   row_cnt_q;

	logic [EW-1:0] width_ext;
	logic [EW-1:0] eff_width;
	logic [11:0]   eff_height;
	logic [EW-1:0] col_plus;
	logic [12:0]   row_plus;
	logic          col_end;
	logic          row_end;
	logic          in_region;

	// Input stage.
	logic [PIX_W-1:0] gray_s1;
	logic [CW-1:0]    col_s1;
	logic             region_s1;
	logic             last_s1;

	logic [PIX_W-1:0] upper_rd;
	logic [PIX_W-1:0] middle_rd;
	logic             edge_hit;

	gpet_res_t res_q;

	gpet_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The stage ahead drains when the output register is empty or being
	// taken, so a new pixel can enter on every clock unless the output stalls.
	assign advance     = s1_valid_q && (!out_valid_q || result.ready);
	assign pixel.ready = !s1_valid_q || advance;
	assign accept      = pixel.valid && pixel.ready;

	// Clamp the programmed geometry to what the line stores can hold.
	assign width_ext = EW'(cfg.image_width);
	always_comb begin
		priority if (width_ext < EW'(MIN_DIM)) begin
			eff_width = EW'(MIN_DIM);
		end else if (width_ext > EW'(MAX_WIDTH)) begin
			eff_width = EW'(MAX_WIDTH);
		end else begin
			eff_width = width_ext;
		end
	end
	assign eff_height = (cfg.image_height < 12'(MIN_DIM)) ? 12'(MIN_DIM) : cfg.image_height;

	// A counter at or past the last position wraps, which also covers a
	// geometry change in the middle of a frame.
	assign col_plus  = EW'(col_cnt_q) + EW'(1);
	assign row_plus  = {1'b0, row_cnt_q} + 13'd1;
	assign col_end   = col_plus >= eff_width;
	assign row_end   = row_plus >= {1'b0, eff_height};
	assign in_region = (EW'(col_cnt_q) >= EW'(MIN_DIM)) && (EW'(col_cnt_q) < eff_width)
		&& (row_cnt_q >= 12'(MIN_DIM)) && (row_cnt_q < eff_height);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
			row_cnt_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_cnt_q <= '0;
				row_cnt_q <= row_end ? 12'd0 : row_plus[11:0];
			end else begin
				col_cnt_q <= col_plus[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gray_s1   <= gray_of(pixel.red, pixel.green, pixel.blue);
			col_s1    <= col_cnt_q;
			region_s1 <= in_region;
			last_s1   <= col_end && row_end;
		end
	end

	// Read at acceptance so the column's history is registered alongside
	// the pixel; the write back happens as the pixel leaves the stage.
	gpet_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_lines (
		.clk       (clk),
		.rd_en     (accept),
		.rd_addr   (col_cnt_q),
		.wr_en     (advance),
		.wr_addr   (col_s1),
		.wr_upper  (middle_rd),
		.wr_middle (gray_s1),
		.rd_upper  (upper_rd),
		.rd_middle (middle_rd)
	);

	gpet_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.shift     (advance),
		.right_top (upper_rd),
		.right_mid (middle_rd),
		.right_bot (gray_s1),
		.threshold (cfg.edge_threshold),
		.edge_hit  (edge_hit)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.gray_value <= gray_s1;
			res_q.edge_valid <= region_s1;
			res_q.edge_pixel <= (region_s1 && edge_hit) ? EDGE_ON : EDGE_OFF;
			res_q.frame_last <= last_s1;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.gray_value = res_q.gray_value;
	assign result.edge_valid = res_q.edge_valid;
	assign result.edge_pixel = res_q.edge_pixel;
	assign result.frame_last = res_q.frame_last;

	// The column position always addresses a line store entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		EW'(col_cnt_q) < EW'(MAX_WIDTH))
		else $error("column counter beyond line store depth");

	// A full input stage behind a stalled output must hold off the source.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_valid_q && !result.ready) |-> !pixel.ready)
		else $error("pixel accepted while both stages are blocked");

	// The last pixel of a frame returns the position to the frame origin.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && col_end && row_end) |=> (col_cnt_q == '0 && row_cnt_q == 12'd0))
		else $error("frame position not reset after last pixel");

	// An edge mark only appears for a processed anchor, and only as 255.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result.edge_pixel != EDGE_OFF)
		|-> (result.edge_valid && result.edge_pixel == EDGE_ON))
		else $error("edge mark outside processed region or malformed");

endmodule
`default_nettype wire

// File: hw/rtl/gpet_apb_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpet_apb_regs
// APB register file holding frame width, frame height and edge threshold.
// ----------------------------------------------------------------------------
module gpet_apb_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [gpet_pkg::ADDR_W-1:0] paddr,
	input  wire logic [gpet_pkg::DATA_W-1:0] pwdata,
	output logic      [gpet_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	output gpet_pkg::gpet_cfg_t              cfg
);
	import gpet_pkg::*;

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;
	gpet_cfg_t            cfg_q;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width    <= RST_IMAGE_WIDTH;
			cfg_q.image_height   <= RST_IMAGE_HEIGHT;
			cfg_q.edge_threshold <= RST_EDGE_THRESHOLD;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_IMAGE_WIDTH:    cfg_q.image_width    <= pwdata[10:0];
				REG_IMAGE_HEIGHT:   cfg_q.image_height   <= pwdata[11:0];
				REG_EDGE_THRESHOLD: cfg_q.edge_threshold <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_IMAGE_WIDTH:    prdata = DATA_W'(cfg_q.image_width);
			REG_IMAGE_HEIGHT:   prdata = DATA_W'(cfg_q.image_height);
			REG_EDGE_THRESHOLD: prdata = DATA_W'(cfg_q.edge_threshold);
			default:            prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// File: hw/rtl/gpet_line_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpet_line_store
// Two line memories (rows r-2 and r-1) sharing one read and one write address.
// ----------------------------------------------------------------------------
module gpet_line_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic                        clk,
	input  wire logic                        rd_en,
	input  wire logic [AW-1:0]               rd_addr,
	input  wire logic                        wr_en,
	input  wire logic [AW-1:0]               wr_addr,
	input  wire logic [gpet_pkg::PIX_W-1:0]  wr_upper,
	input  wire logic [gpet_pkg::PIX_W-1:0]  wr_middle,
	output logic      [gpet_pkg::PIX_W-1:0]  rd_upper,
	output logic      [gpet_pkg::PIX_W-1:0]  rd_middle
);
	import gpet_pkg::*;

	logic [PIX_W-1:0] upper_mem   [DEPTH];
	logic [PIX_W-1:0] middle_mem  [DEPTH];
	logic [PIX_W-1:0] upper_rd_q;
	logic [PIX_W-1:0] middle_rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			upper_mem[wr_addr]  <= wr_upper;
			middle_mem[wr_addr] <= wr_middle;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			upper_rd_q  <= upper_mem[rd_addr];
			middle_rd_q <= middle_mem[rd_addr];
		end
	end

	assign rd_upper  = upper_rd_q;
	assign rd_middle = middle_rd_q;

endmodule
`default_nettype wire

// File: hw/rtl/gpet_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpet_window
// 3x3 gray window: two stored columns plus the incoming right column, with
// the combined Prewitt response compared against the threshold.
// ----------------------------------------------------------------------------
module gpet_window (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       shift,
	input  wire logic [gpet_pkg::PIX_W-1:0] right_top,
	input  wire logic [gpet_pkg::PIX_W-1:0] right_mid,
	input  wire logic [gpet_pkg::PIX_W-1:0] right_bot,
	input  wire logic [10:0]                threshold,
	output logic                            edge_hit
);
	import gpet_pkg::*;

	// Entries 0..2: left column (top, mid, bottom); 3..5: middle column.
	logic [PIX_W-1:0]  win_q [6];
	logic [9:0]        pos_sum;
	logic [9:0]        neg_sum;
	logic signed [11:0] resp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
		end else if (shift) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= right_top;
			win_q[4] <= right_mid;
			win_q[5] <= right_bot;
		end
	end

	// gx + gy folds to (m2 + 2*b2 + b1) - (2*t0 + m0 + t1).
	assign pos_sum = 10'(right_mid) + {1'b0, right_bot, 1'b0} + 10'(win_q[5]);
	assign neg_sum = {1'b0, win_q[0], 1'b0} + 10'(win_q[1]) + 10'(win_q[3]);
	assign resp    = $signed({2'b00, pos_sum}) - $signed({2'b00, neg_sum});
	assign edge_hit = resp > $signed({1'b0, threshold});

endmodule
`default_nettype wire
